FILE: rtl/fit_policy_block_allocator_unit_defines.svh
// Assertion macros for the fit policy block allocator.
// Pulled in by the RTL files that carry concurrent checks; no other dependencies.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define FPBA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fpba: same-cycle check failed");

// next-cycle implication, reset masks the check
`define FPBA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fpba: next-cycle check failed");

`endif

FILE: rtl/fpba_pkg.sv
// Shared types and constants for the fit policy block allocator.
// No dependencies; imported by fpba_cell and the top level.
`timescale 1ns / 1ps

package fpba_pkg;

    // default table geometry
    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int SLOT_W = 4;
    localparam int AMT_W  = 16;
    localparam int CNT_W  = 5;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FIRST = 2'd1,
        CMD_BEST  = 2'd2,
        CMD_WORST = 2'd3
    } cmd_t;

    // request held steady for the whole scan
    typedef struct packed {
        cmd_t             cmd;
        logic [AMT_W-1:0] amt;
    } scan_ctl_t;

endpackage

FILE: rtl/fpba_cell.sv
// One allocator cell: holds a block's remaining size and updates the passing search word.
// Depends on fpba_pkg.
`timescale 1ns / 1ps

module fpba_cell #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16,
    parameter int IDX        = 0,
    parameter int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [fpba_pkg::CNT_W-1:0]    blk_count,
    input  fpba_pkg::scan_ctl_t           ctl,
    input  logic                          in_found,
    input  logic [IDX_W-1:0]              in_idx,
    input  logic [SIZE_BITS-1:0]          in_size,
    output logic                          out_found,
    output logic [IDX_W-1:0]              out_idx,
    output logic [SIZE_BITS-1:0]          out_size,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_idx,
    input  logic [SIZE_BITS-1:0]          wr_data
);
    import fpba_pkg::*;

    localparam int CW = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

    logic [SIZE_BITS-1:0] size_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SIZE_BITS-1:0] best_reg;
    logic                 active;
    logic                 fits;
    logic                 take;

    // only blocks below the programmed count take part
    assign active = (32'(blk_count) > IDX);
    assign fits   = (CW'(size_reg) >= CW'(ctl.amt));

    // policy decision against the incoming candidate; strict compares keep ties low
    always_comb begin
        case (ctl.cmd)
            CMD_FIRST: take = active && fits && !in_found;
            CMD_BEST:  take = active && fits && (!in_found || size_reg < in_size);
            CMD_WORST: take = active && (!in_found || size_reg > in_size);
            default:   take = 1'b0;
        endcase
    end

    // search word moves one cell per clock
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= in_found || take;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= take ? IDX_W'(IDX) : in_idx;
        best_reg <= take ? size_reg : in_size;
    end

    // block size store, written by load or by grant write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= '0;
        end else if (wr_en && wr_idx == IDX_W'(IDX)) begin
            size_reg <= wr_data;
        end
    end

    assign out_found = found_reg;
    assign out_idx   = idx_reg;
    assign out_size  = best_reg;

endmodule

FILE: rtl/fit_policy_block_allocator_unit.sv
// Fit policy block allocator, top level: controller, result register and the cell chain.
// Depends on fpba_pkg, fpba_cell and fit_policy_block_allocator_unit_defines.svh.
//
// Usage:
//  - Input channel s_*: one word carries command, block_slot and amount. A load
//    command writes one block's size; first, best and worst fit commands search
//    the blocks below block_count and shrink the chosen one by the request.
//  - Result channel m_*: one word per input word, granted, chosen_block and
//    left_over, held in an output register until taken.
//  - Config channel cfg_*: writes block_count; always ready. Write it while idle.
//  - Sequence: a load is answered in the cycle after acceptance. An allocation
//    walks the search word along the chain one cell per clock, then the finish
//    state writes the chosen block back and loads the result.
//  - Throughput: a new allocation is taken only once the last one has finished;
//    loads go at one per cycle while idle and while the result side keeps up.
//  - Reset: all block sizes and block_count clear to zero, no result pending.
//  - Stall: a waiting result does not stop a new allocation from starting; the
//    write-back waits until the output register is free, and loads wait likewise.
`timescale 1ns / 1ps

`include "fit_policy_block_allocator_unit_defines.svh"

module fit_policy_block_allocator_unit #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fpba_pkg::CNT_W-1:0]    cfg_data,
    // request words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fpba_pkg::CMD_W-1:0]    s_command,
    input  logic [fpba_pkg::SLOT_W-1:0]   s_block_slot,
    input  logic [fpba_pkg::AMT_W-1:0]    s_amount,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_granted,
    output logic [fpba_pkg::SLOT_W-1:0]   m_chosen_block,
    output logic [fpba_pkg::AMT_W-1:0]    m_left_over
);
    import fpba_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW    = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]     blk_count_reg;
    scan_ctl_t            ctl_reg;

    logic                 m_valid_reg;
    logic                 m_granted_reg;
    logic [SLOT_W-1:0]    m_chosen_reg;
    logic [AMT_W-1:0]     m_left_reg;

    logic                 out_free;
    logic                 load_fire;
    logic                 alloc_fire;
    logic                 finish_fire;
    logic                 slot_ok;
    logic                 sat;
    logic [SIZE_BITS-1:0] load_val;
    logic                 grant;
    logic [SIZE_BITS-1:0] new_size;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [SIZE_BITS-1:0] wr_data;

    // search word taps between the cells
    logic                 chain_found [0:NUM_BLOCKS];
    logic [IDX_W-1:0]     chain_idx   [0:NUM_BLOCKS];
    logic [SIZE_BITS-1:0] chain_size  [0:NUM_BLOCKS];

    // handshakes
    assign cfg_ready   = 1'b1;
    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == ST_IDLE) && (cmd_t'(s_command) != CMD_LOAD || out_free);
    assign load_fire   = s_valid && s_ready && cmd_t'(s_command) == CMD_LOAD;
    assign alloc_fire  = s_valid && s_ready && cmd_t'(s_command) != CMD_LOAD;
    assign finish_fire = (state_reg == ST_FINISH) && out_free;

    // load value, saturated to the block width
    assign slot_ok  = (32'(s_block_slot) < NUM_BLOCKS);
    assign sat      = (CW'(s_amount) > CW'({SIZE_BITS{1'b1}}));
    assign load_val = sat ? {SIZE_BITS{1'b1}} : SIZE_BITS'(s_amount);

    // end of chain: a found candidate still has to fit (worst fit case)
    assign grant    = chain_found[NUM_BLOCKS] &&
                      (CW'(chain_size[NUM_BLOCKS]) >= CW'(ctl_reg.amt));
    assign new_size = chain_size[NUM_BLOCKS] - SIZE_BITS'(ctl_reg.amt);

    // single write port into the cells
    always_comb begin
        if (load_fire) begin
            wr_en   = slot_ok;
            wr_idx  = IDX_W'(s_block_slot);
            wr_data = load_val;
        end else begin
            wr_en   = finish_fire && grant;
            wr_idx  = chain_idx[NUM_BLOCKS];
            wr_data = new_size;
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                scan_cnt_next = '0;
                if (alloc_fire) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == IDX_W'(NUM_BLOCKS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            blk_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            if (cfg_valid && cfg_ready) begin
                blk_count_reg <= cfg_data;
            end
            if (load_fire || finish_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (alloc_fire) begin
            ctl_reg.cmd <= cmd_t'(s_command);
            ctl_reg.amt <= s_amount;
        end
        if (load_fire) begin
            m_granted_reg <= 1'b0;
            m_chosen_reg  <= s_block_slot;
            m_left_reg    <= slot_ok ? AMT_W'(load_val) : '0;
        end else if (finish_fire) begin
            m_granted_reg <= grant;
            m_chosen_reg  <= grant ? SLOT_W'(chain_idx[NUM_BLOCKS]) : '0;
            m_left_reg    <= grant ? AMT_W'(new_size) : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_granted      = m_granted_reg;
    assign m_chosen_block = m_chosen_reg;
    assign m_left_over    = m_left_reg;

    // cell chain, fed with an empty candidate
    assign chain_found[0] = 1'b0;
    assign chain_idx[0]   = '0;
    assign chain_size[0]  = '0;

    for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
        fpba_cell #(
            .NUM_BLOCKS (NUM_BLOCKS),
            .SIZE_BITS  (SIZE_BITS),
            .IDX        (i),
            .IDX_W      (IDX_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .blk_count (blk_count_reg),
            .ctl       (ctl_reg),
            .in_found  (chain_found[i]),
            .in_idx    (chain_idx[i]),
            .in_size   (chain_size[i]),
            .out_found (chain_found[i+1]),
            .out_idx   (chain_idx[i+1]),
            .out_size  (chain_size[i+1]),
            .wr_en     (wr_en),
            .wr_idx    (wr_idx),
            .wr_data   (wr_data)
        );
    end

    // checks
    `FPBA_ASSERT_NEXT(a_alloc_starts_scan, aclk, aresetn, alloc_fire, state_reg == ST_SCAN)
    `FPBA_ASSERT_NOW(a_busy_not_ready, aclk, aresetn, state_reg != ST_IDLE, !s_ready)
    `FPBA_ASSERT_NEXT(a_finish_posts_result, aclk, aresetn, finish_fire, m_valid_reg && state_reg == ST_IDLE)

endmodule
